### src/mrmr_pkg.sv
// Package for the mask ROI max-radius block.
// Register map, field widths, derive op codes and the controller/datapath structs.
// No dependencies.
package mrmr_pkg;

  localparam int PIX_W      = 10;  // pixel column/row fields
  localparam int DIM_W      = 11;  // size registers and mask-space bounds
  localparam int SPAN_W     = 12;  // ROI edge and span registers
  localparam int RAD_W      = 11;  // result radius
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MASK_W   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK_H   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REF_W    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REF_H    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROI_L    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROI_T    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROI_SPX  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ROI_SPY  = 3'd7;

  typedef enum logic [2:0] {
    OP_X_LO,
    OP_X_HI,
    OP_X_SC,
    OP_Y_LO,
    OP_Y_HI,
    OP_Y_SC
  } derive_op_t;

  typedef struct packed {
    logic       clr_dirty;
    logic       div_start;
    derive_op_t op;
    logic       take;
    logic       mul1;
    logic       mul2;
    logic       acc;
    logic       sq_init;
    logic       sq_step;
    logic       out_load;
  } mrmr_cmd_t;

  typedef struct packed {
    logic dirty;
    logic div_done;
    logic sq_last;
    logic last;
    logic out_busy;
  } mrmr_sts_t;

endpackage

### src/mrmr_pix_if.sv
// Pixel request channel: valid/ready handshake with mask coordinates and flags.
// No dependencies.
interface mrmr_pix_if #(
  parameter int CW = 10
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] pixel_col;
  logic [CW-1:0] pixel_row;
  logic          pixel_set;
  logic          final_pixel;

  modport source (output valid, pixel_col, pixel_row, pixel_set, final_pixel, input ready);
  modport sink   (input valid, pixel_col, pixel_row, pixel_set, final_pixel, output ready);
endinterface

### src/mrmr_rad_if.sv
// Radius result channel: valid/ready handshake with the radius payload.
// Depends on mrmr_pkg.
interface mrmr_rad_if
  import mrmr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] radius;

  modport source (output valid, radius, input ready);
  modport sink   (input valid, radius, output ready);
endinterface

### src/mrmr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the datapath for bounds and scale derivation.
module mrmr_div #(
  parameter int DVW = 23,
  parameter int DSW = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);
  localparam int CNT_W = $clog2(DVW);

  logic [DVW-1:0]   q_r;
  logic [DSW-1:0]   rem_r;
  logic [DSW-1:0]   dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSW:0]     rem_sh;
  logic             ge;
  logic [DSW:0]     rem_nxt;

  assign rem_sh  = {rem_r, q_r[DVW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(DVW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVW - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVW-2:0], ge};
      rem_r <= rem_nxt[DSW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

### src/mrmr_dp.sv
// Datapath: config registers, bound/scale derivation, distance pipeline,
// max tracking, digit-serial square root and result register. Uses mrmr_pkg, mrmr_div.
module mrmr_dp
  import mrmr_pkg::*;
#(
  parameter int MAX_DIM         = 1024,
  parameter int SCALE_FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mrmr_cmd_t                cmd,
  output mrmr_sts_t                sts,
  input  logic [PIX_W-1:0]         in_col,
  input  logic [PIX_W-1:0]         in_row,
  input  logic                     in_set,
  input  logic                     in_last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [RAD_W-1:0]         out_radius
);
  localparam int F     = SCALE_FRAC_BITS;
  localparam int PCW   = PIX_W;
  localparam int SW    = DIM_W + F;
  localparam int PW    = DIM_W + SW;
  localparam int MW    = 2 * PW + 1;
  localparam int RW    = (MW + 1) / 2;
  localparam int RCW   = $clog2(RW);
  localparam int DVW   = (2 * DIM_W + 1 > SW) ? 2 * DIM_W + 1 : SW;
  localparam int EW    = SPAN_W + 2;
  localparam int CXW   = DIM_W + 2;

  // configuration registers
  logic [DIM_W-1:0]         mw_r, mh_r, rfw_r, rfh_r;
  logic signed [SPAN_W-1:0] left_r, top_r;
  logic [SPAN_W-1:0]        spx_r, spy_r;
  logic                     dirty_r;
  logic                     wr;
  logic [REG_IDX_W-1:0]     idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r    <= DIM_W'(MAX_DIM);
      mh_r    <= DIM_W'(MAX_DIM);
      rfw_r   <= DIM_W'(MAX_DIM);
      rfh_r   <= DIM_W'(MAX_DIM);
      left_r  <= '0;
      top_r   <= '0;
      spx_r   <= SPAN_W'(MAX_DIM);
      spy_r   <= SPAN_W'(MAX_DIM);
      dirty_r <= 1'b1;
    end else begin
      if (wr) begin
        dirty_r <= 1'b1;
        case (idx)
          REG_MASK_W:  mw_r   <= pwdata[DIM_W-1:0];
          REG_MASK_H:  mh_r   <= pwdata[DIM_W-1:0];
          REG_REF_W:   rfw_r  <= pwdata[DIM_W-1:0];
          REG_REF_H:   rfh_r  <= pwdata[DIM_W-1:0];
          REG_ROI_L:   left_r <= signed'(pwdata[SPAN_W-1:0]);
          REG_ROI_T:   top_r  <= signed'(pwdata[SPAN_W-1:0]);
          REG_ROI_SPX: spx_r  <= pwdata[SPAN_W-1:0];
          REG_ROI_SPY: spy_r  <= pwdata[SPAN_W-1:0];
          default: ;
        endcase
      end else if (cmd.clr_dirty) begin
        dirty_r <= 1'b0;
      end
    end
  end

  always_comb begin
    case (idx)
      REG_MASK_W:  prdata = CFG_DATA_W'(mw_r);
      REG_MASK_H:  prdata = CFG_DATA_W'(mh_r);
      REG_REF_W:   prdata = CFG_DATA_W'(rfw_r);
      REG_REF_H:   prdata = CFG_DATA_W'(rfh_r);
      REG_ROI_L:   prdata = {{(CFG_DATA_W-SPAN_W){1'b0}}, left_r};
      REG_ROI_T:   prdata = {{(CFG_DATA_W-SPAN_W){1'b0}}, top_r};
      REG_ROI_SPX: prdata = CFG_DATA_W'(spx_r);
      REG_ROI_SPY: prdata = CFG_DATA_W'(spy_r);
      default:     prdata = '0;
    endcase
  end

  // derivation operands
  function automatic logic [DIM_W-1:0] clamp_edge(input logic signed [EW-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic signed [EW-1:0] hs;
    hs = signed'(EW'(hi));
    if (v < 0) return '0;
    else if (v > hs) return hi;
    else return v[DIM_W-1:0];
  endfunction

  logic                     y_axis;
  logic [DIM_W-1:0]         m_raw, r_raw, m_nz, r_nz, a_clp, b_clp;
  logic signed [SPAN_W-1:0] st;
  logic [SPAN_W-1:0]        sp;
  logic signed [EW-1:0]     lo_e, hi_e;
  logic [2*DIM_W-1:0]       prod_a, prod_b;
  logic [DVW-1:0]           dvd;
  logic [DIM_W-1:0]         dsr;
  logic                     div_done;
  logic [DVW-1:0]           quo;

  always_comb begin
    y_axis = cmd.op inside {OP_Y_LO, OP_Y_HI, OP_Y_SC};
    m_raw  = y_axis ? mh_r : mw_r;
    r_raw  = y_axis ? rfh_r : rfw_r;
    st     = y_axis ? top_r : left_r;
    sp     = y_axis ? spy_r : spx_r;
    m_nz   = (m_raw == '0) ? DIM_W'(1) : m_raw;
    r_nz   = (r_raw == '0) ? DIM_W'(1) : r_raw;
    lo_e   = EW'(st);
    hi_e   = lo_e + signed'(EW'(sp));
    a_clp  = clamp_edge(lo_e, r_nz);
    b_clp  = clamp_edge(hi_e, r_nz);
    prod_a = a_clp * m_nz;
    prod_b = b_clp * m_nz;
    case (cmd.op)
      OP_X_LO, OP_Y_LO: begin
        dvd = DVW'(prod_a);
        dsr = r_nz;
      end
      OP_X_HI, OP_Y_HI: begin
        dvd = DVW'(prod_b) + DVW'(r_nz) - DVW'(1);
        dsr = r_nz;
      end
      default: begin
        dvd = DVW'(r_nz) << F;
        dsr = m_nz;
      end
    endcase
  end

  mrmr_div #(.DVW(DVW), .DSW(DIM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

  logic [DIM_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [SW-1:0]    sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.op)
        OP_X_LO: x0_r <= quo[DIM_W-1:0];
        OP_X_HI: x1_r <= quo[DIM_W-1:0];
        OP_X_SC: sx_r <= quo[SW-1:0];
        OP_Y_LO: y0_r <= quo[DIM_W-1:0];
        OP_Y_HI: y1_r <= quo[DIM_W-1:0];
        OP_Y_SC: sy_r <= quo[SW-1:0];
        default: ;
      endcase
    end
  end

  // distance pipeline
  logic [PCW-1:0]   col_r, row_r;
  logic             set_r, last_r, hit_r;
  logic [DIM_W-1:0] col_e, row_e, dx_abs, dy_abs;
  logic [CXW-1:0]   tx, ty, cx, cy, dfx, dfy;
  logic             in_roi;
  logic [PW-1:0]    dx_r, dy_r, dx_nxt, dy_nxt;
  logic [2*PW-1:0]  sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [MW-1:0]    sum, max_r;

  always_comb begin
    col_e   = DIM_W'(col_r);
    row_e   = DIM_W'(row_r);
    in_roi  = (col_e >= x0_r) && (col_e < x1_r) && (row_e >= y0_r) && (row_e < y1_r);
    tx      = CXW'(col_e) << 1;
    ty      = CXW'(row_e) << 1;
    cx      = CXW'(x0_r) + CXW'(x1_r);
    cy      = CXW'(y0_r) + CXW'(y1_r);
    dfx     = (tx >= cx) ? tx - cx : cx - tx;
    dfy     = (ty >= cy) ? ty - cy : cy - ty;
    dx_abs  = dfx[DIM_W-1:0];
    dy_abs  = dfy[DIM_W-1:0];
    dx_nxt  = dx_abs * sx_r;
    dy_nxt  = dy_abs * sy_r;
    sqx_nxt = dx_r * dx_r;
    sqy_nxt = dy_r * dy_r;
    sum     = MW'(sqx_r) + MW'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      col_r  <= in_col;
      row_r  <= in_row;
      set_r  <= in_set;
      last_r <= in_last;
    end
    if (cmd.mul1) begin
      hit_r <= set_r & in_roi;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
    end
    if (cmd.mul2) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
    end
  end

  // square root, two radicand bits per step
  logic [2*RW-1:0] sqv_r;
  logic [RW-1:0]   root_r;
  logic [RW:0]     rem_r;
  logic [RCW-1:0]  cnt_r;
  logic [RW+2:0]   rem_sh, trial, rem_df;
  logic            ge;
  logic            out_valid_r;
  logic [RAD_W-1:0] radius_r;

  assign rem_sh = {rem_r, sqv_r[2*RW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_df = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc && hit_r && (sum > max_r)) max_r <= sum;
      if (cmd.sq_init) max_r <= '0;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sqv_r  <= (2*RW)'(max_r);
      root_r <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.sq_step) begin
      sqv_r  <= sqv_r << 2;
      root_r <= {root_r[RW-2:0], ge};
      rem_r  <= rem_df[RW:0];
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.out_load) radius_r <= root_r[F+1 +: RAD_W];
  end

  assign sts.dirty    = dirty_r;
  assign sts.div_done = div_done;
  assign sts.sq_last  = (cnt_r == RCW'(RW - 1));
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r & ~out_ready;

  assign out_valid  = out_valid_r;
  assign out_radius = radius_r;
endmodule

### src/mrmr_ctrl.sv
// Controller: sequences derivation, the per-pixel distance steps,
// the square root and the result hand-off. Uses mrmr_pkg.
module mrmr_ctrl
  import mrmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mrmr_sts_t sts,
  output mrmr_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_SQ_INIT,
    S_SQ_RUN,
    S_SQ_OUT
  } state_t;

  state_t     state_r;
  derive_op_t op_r;

  assign in_ready = (state_r == S_IDLE) && !sts.dirty;

  always_comb begin
    cmd           = '0;
    cmd.op        = op_r;
    cmd.clr_dirty = (state_r == S_IDLE) && sts.dirty;
    cmd.take      = in_ready && in_valid;
    cmd.div_start = (state_r == S_DIV_GO);
    cmd.mul1      = (state_r == S_MUL1);
    cmd.mul2      = (state_r == S_MUL2);
    cmd.acc       = (state_r == S_ACC);
    cmd.sq_init   = (state_r == S_SQ_INIT);
    cmd.sq_step   = (state_r == S_SQ_RUN);
    cmd.out_load  = (state_r == S_SQ_OUT) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_X_LO;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (sts.dirty) begin
            op_r    <= OP_X_LO;
            state_r <= S_DIV_GO;
          end else if (in_valid) begin
            state_r <= S_MUL1;
          end
        end
        S_DIV_GO:   state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            if (op_r == OP_Y_SC) begin
              state_r <= S_IDLE;
            end else begin
              op_r    <= derive_op_t'(op_r + 1'b1);
              state_r <= S_DIV_GO;
            end
          end
        end
        S_MUL1:    state_r <= S_MUL2;
        S_MUL2:    state_r <= S_ACC;
        S_ACC:     state_r <= sts.last ? S_SQ_INIT : S_IDLE;
        S_SQ_INIT: state_r <= S_SQ_RUN;
        S_SQ_RUN:  if (sts.sq_last) state_r <= S_SQ_OUT;
        S_SQ_OUT:  if (!sts.out_busy) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### src/mask_roi_max_radius_core.sv
// Mask ROI max radius: top level joining controller and datapath.
// Per pixel request: take, two multiply stages, max update; then the next request.
// The final pixel then runs the root: init, one root digit per step, result load.
// Any register write reruns derivation: 6 divisions, run one after another.
// rst_n is synchronous; after reset derivation runs before the first pixel is taken.
module mask_roi_max_radius_core
  import mrmr_pkg::*;
#(
  parameter int MAX_DIM         = 1024,
  parameter int SCALE_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mrmr_pix_if.sink              in_ch,
  mrmr_rad_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);
  mrmr_cmd_t cmd;
  mrmr_sts_t sts;

  assign pready = 1'b1;

  mrmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrmr_dp #(.MAX_DIM(MAX_DIM), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_col     (in_ch.pixel_col),
    .in_row     (in_ch.pixel_row),
    .in_set     (in_ch.pixel_set),
    .in_last    (in_ch.final_pixel),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_radius (out_ch.radius)
  );
endmodule

### src/mrmr_chk.sv
// Port-level checker for the mask ROI max radius core, bound to the top level.
// Uses mrmr_pkg.
module mrmr_chk
  import mrmr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RAD_W-1:0] out_radius,
  input logic             cfg_wr
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_radius)) else $error("radius changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("request taken while busy");

  a_cfg_rederive: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ready) else $error("request taken before rederive");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready)) else $error("result without root pass");
endmodule

bind mask_roi_max_radius_core mrmr_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_radius (out_ch.radius),
  .cfg_wr     (psel & penable & pwrite)
);

### tb/mask_roi_max_radius_core_test.sv
// Testbench for mask_roi_max_radius_core: drives pixel requests and APB register writes,
// predicts the radius of each scan and checks every result in order.
// Depends on mrmr_pkg, mrmr_pix_if and mrmr_rad_if.
`timescale 1ns / 100ps

module mask_roi_max_radius_core_test
  import mrmr_pkg::*;
;

  localparam int FRAC = 8;

  class radius_board;
    longint unsigned msz[2], rsz[2];
    longint signed   start[2];
    longint unsigned span[2];
    longint unsigned lo[2], hi[2], sc[2];
    longint unsigned peak_sq;
    bit [RAD_W-1:0]  radius_q[$];
    int              errors;
    int              results;

    function void reset_regs();
      for (int a = 0; a < 2; a++) begin
        msz[a] = 1024; rsz[a] = 1024; start[a] = 0; span[a] = 1024;
      end
      peak_sq = 0;
      remap();
    endfunction

    function void remap();
      longint unsigned m, r, ea, eb;
      longint signed   e;
      for (int a = 0; a < 2; a++) begin
        m = msz[a] == 0 ? 1 : msz[a];
        r = rsz[a] == 0 ? 1 : rsz[a];
        e = start[a];
        ea = e < 0 ? 0 : (e > longint'(r) ? r : e);
        e = start[a] + longint'(span[a]);
        eb = e < 0 ? 0 : (e > longint'(r) ? r : e);
        lo[a] = (ea * m) / r;
        hi[a] = (eb * m + r - 1) / r;
        sc[a] = (r << FRAC) / m;
      end
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_MASK_W:  msz[0] = v[10:0];
        REG_MASK_H:  msz[1] = v[10:0];
        REG_REF_W:   rsz[0] = v[10:0];
        REG_REF_H:   rsz[1] = v[10:0];
        REG_ROI_L:   start[0] = longint'($signed(v[11:0]));
        REG_ROI_T:   start[1] = longint'($signed(v[11:0]));
        REG_ROI_SPX: span[0] = v[11:0];
        REG_ROI_SPY: span[1] = v[11:0];
        default: ;
      endcase
      remap();
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint unsigned axis_off(int a, longint unsigned p);
      longint unsigned t, c;
      t = 2 * p;
      c = lo[a] + hi[a];
      return (t >= c ? t - c : c - t) * sc[a];
    endfunction

    function void note_pixel(bit [9:0] col, bit [9:0] row, bit set, bit last);
      longint unsigned dx, dy, d2;
      longint unsigned r;
      if (set && col >= lo[0] && col < hi[0] && row >= lo[1] && row < hi[1]) begin
        dx = axis_off(0, col);
        dy = axis_off(1, row);
        d2 = dx * dx + dy * dy;
        if (d2 > peak_sq) peak_sq = d2;
      end
      if (last) begin
        r = root(peak_sq) >> (FRAC + 1);
        radius_q.push_back(r[RAD_W-1:0]);
        peak_sq = 0;
      end
    endfunction

    task report_err(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_radius(bit [RAD_W-1:0] got);
      bit [RAD_W-1:0] want;
      results++;
      if (radius_q.size() == 0) begin
        report_err($sformatf("radius %0d with no scan pending", got));
        return;
      end
      want = radius_q.pop_front();
      if (got !== want)
        report_err($sformatf("radius %0d, predicted %0d", got, want));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  mrmr_pix_if in_ch ();
  mrmr_rad_if out_ch ();

  mask_roi_max_radius_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  radius_board board;
  int idle_cycles = 0;
  int scans = 0;
  bit in_fire, out_fire;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.pixel_col = 0; in_ch.pixel_row = 0;
    in_ch.pixel_set = 0; in_ch.final_pixel = 0;
    out_ch.ready = 0;
    board = new();
    board.reset_regs();
  end

  // sample at rising edge
  always @(posedge clk) begin
    in_fire = in_ch.valid && in_ch.ready;
    out_fire = out_ch.valid && out_ch.ready;
    if (out_fire && rst_n) board.check_radius(out_ch.radius);
    if (in_fire || out_fire || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side stall: per result, ready is held low until valid, then raised after a random wait
  initial begin
    @(posedge rst_n);
    forever begin
      int w;
      w = $urandom_range(0, 4);
      @(negedge clk);
      out_ch.ready <= 1'b0;
      while (!out_ch.valid) @(negedge clk);
      repeat (w) @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (board.radius_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_pixel(bit [9:0] col, bit [9:0] row, bit set, bit last,
                            bit gaps = 1);
    int w;
    w = gaps ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    repeat (w) @(negedge clk);
    in_ch.valid <= 1; in_ch.pixel_col <= col; in_ch.pixel_row <= row;
    in_ch.pixel_set <= set; in_ch.final_pixel <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    board.note_pixel(col, row, set, last);
    if (last) scans++;
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic config_all(int mw, int mh, int rw, int rh, int l, int t, int sx, int sy);
    cfg_write(REG_MASK_W, mw);  cfg_write(REG_MASK_H, mh);
    cfg_write(REG_REF_W, rw);   cfg_write(REG_REF_H, rh);
    cfg_write(REG_ROI_L, l);    cfg_write(REG_ROI_T, t);
    cfg_write(REG_ROI_SPX, sx); cfg_write(REG_ROI_SPY, sy);
  endtask

  task automatic random_scan(int mw, int mh, int n);
    bit [9:0] c, r;
    bit g;
    g = $urandom_range(0, 3) != 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = 10'($urandom); r = 10'($urandom);
      end else begin
        c = 10'($urandom_range(0, mw - 1)); r = 10'($urandom_range(0, mh - 1));
      end
      send_pixel(c, r, $urandom_range(0, 2) != 0, i == n - 1, g);
    end
  endtask

  initial begin
    int mw, mh, sent;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (200) @(posedge clk);
    // directed: corners and extremes under reset config
    send_pixel(0, 0, 1, 0);
    send_pixel(1023, 1023, 1, 0);
    send_pixel(1023, 0, 0, 0);
    send_pixel(512, 512, 1, 1);
    send_pixel(5, 5, 0, 1);               // empty scan
    send_pixel(0, 1023, 1, 1);
    drain();
    // zero sizes, ROI clamp and negative edge
    config_all(0, 0, 0, 0, 12'h800, 12'h800, 12'hFFF, 12'hFFF);
    send_pixel(0, 0, 1, 0);
    send_pixel(1, 1, 1, 1);
    drain();
    config_all(2047, 1, 1, 2047, 1024, -5, 0, 2048);
    send_pixel(1023, 0, 1, 0);
    send_pixel(0, 0, 1, 1);
    drain();
    config_all(16, 8, 1024, 777, -3, 4, 10, 2000);
    send_pixel(15, 7, 1, 0);
    send_pixel(0, 0, 1, 0);
    send_pixel(3, 3, 1, 1);
    drain();
    sent = 13;
    // random phases
    while (sent < 1350) begin
      int n;
      mw = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 64);
      mh = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 64);
      config_all(mw, mh, $urandom_range(0, 2047), $urandom_range(0, 2047),
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
      if ($urandom_range(0, 1)) config_all(mw, mh, $urandom_range(1, 1024),
                 $urandom_range(1, 1024), $urandom_range(0, 40),
                 $urandom_range(0, 40), $urandom_range(1, 1200), $urandom_range(1, 1200));
      for (int s = 0; s < 4; s++) begin
        n = $urandom_range(1, 20);
        random_scan(mw > 1024 ? 1024 : mw, mh > 1024 ? 1024 : mh, n);
        sent += n;
      end
      drain();
    end
    repeat (300) @(posedge clk);
    $display("covered %0d scans, %0d radius results checked", scans, board.results);
    if (board.errors == 0 && board.radius_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (board.radius_q.size() != 0) $display("ERROR: %0d results missing",
                                                board.radius_q.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule
